[rtl/core/lcg_pkg.sv]
// Shared types, constants and the color wheel function for the LED color effect generator.
// Used by every module of the core; no dependencies.
`timescale 1ns / 1ps

package lcg_pkg;

    localparam int NUM_PIXELS_DEF  = 18;
    localparam int NUM_EFFECTS     = 7;
    localparam int PIXEL_IDX_W     = 5;
    localparam int CFG_ADDR_W      = 3;

    localparam logic [7:0] TRI_SPACING_RST = 8'd85;
    localparam logic [7:0] DOT_SPACING_RST = 8'd14;
    localparam logic [3:0] FADE_SPEED_RST  = 4'd5;
    localparam logic [3:0] SPEED_MIN       = 4'd1;
    localparam logic [3:0] SPEED_MAX       = 4'd10;
    localparam logic [7:0] TRI_FADE_STEP   = 8'd20;
    localparam logic [7:0] PERIOD_BASE     = 8'd105;
    localparam logic [7:0] TEMP_COLD_POS   = 8'd170;
    localparam logic [7:0] TEMP_HOT_POS    = 8'd0;
    localparam logic signed [7:0] TEMP_HOT_C = 8'sd35;
    localparam logic [7:0] WHEEL_THIRD     = 8'd85;
    localparam logic [7:0] WHEEL_TWO_THIRD = 8'd170;
    localparam logic [7:0] WHEEL_MAX       = 8'd255;

    localparam logic CFG_TRI_SPACING = 1'b0;
    localparam logic CFG_DOT_SPACING = 1'b1;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_NEXT    = 3'd1,
        OP_PREV    = 3'd2,
        OP_UP      = 3'd3,
        OP_DOWN    = 3'd4,
        OP_PAUSE   = 3'd5,
        OP_UNPAUSE = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        EFF_SINGLE      = 3'd0,
        EFF_SINGLE_FADE = 3'd1,
        EFF_TRI         = 3'd2,
        EFF_TRI_FADE    = 3'd3,
        EFF_DOT         = 3'd4,
        EFF_DOT_FADE    = 3'd5,
        EFF_TEMP        = 3'd6
    } effect_t;

    typedef enum logic [1:0] {
        KIND_SAME = 2'd0,
        KIND_TRI  = 2'd1,
        KIND_DOT  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] base;
        logic [7:0] step;
    } frame_desc_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    function automatic logic [7:0] times3(input logic [7:0] v);
        logic [9:0] m;
        m = {2'b00, v} + {1'b0, v, 1'b0};
        return m[7:0];
    endfunction

    function automatic rgb_t wheel(input logic [7:0] pos);
        logic [7:0] w;
        logic [7:0] t;
        rgb_t c;
        w = ~pos;
        if (w < WHEEL_THIRD) begin
            t = times3(w);
            c.r = WHEEL_MAX - t;
            c.g = 8'd0;
            c.b = t;
        end else if (w < WHEEL_TWO_THIRD) begin
            t = times3(w - WHEEL_THIRD);
            c.r = 8'd0;
            c.g = t;
            c.b = WHEEL_MAX - t;
        end else begin
            t = times3(w - WHEEL_TWO_THIRD);
            c.r = t;
            c.g = WHEEL_MAX - t;
            c.b = 8'd0;
        end
        return c;
    endfunction

endpackage

[rtl/core/led_color_effect_generator_core.sv]
// Top level of the LED color effect generator: configuration registers and block wiring.
// Depends on lcg_pkg, lcg_front, lcg_queue and lcg_back.
`timescale 1ns / 1ps

// An input item (tick or button) is taken when s_valid and s_ready are high; s_ready stays
// high while the two-entry frame queue has room. An item that renders queues one frame, and
// the pixel engine emits it as NUM_PIXELS results, one per cycle when m_ready stays high,
// then fetches the next frame from the queue before it emits again. Registers: tri_spacing
// at 0x0, dot_spacing at 0x4.
module led_color_effect_generator_core
    import lcg_pkg::*;
#(
    parameter int NUM_PIXELS = NUM_PIXELS_DEF
)
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [2:0]             s_operation,
    input  logic signed [7:0]      s_temperature_c,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [PIXEL_IDX_W-1:0] m_pixel_index,
    output logic [7:0]             m_red,
    output logic [7:0]             m_green,
    output logic [7:0]             m_blue,
    output logic                   m_last
);

    logic [7:0]  tri_spacing_reg;
    logic [7:0]  dot_spacing_reg;
    logic        cfg_wr;
    logic        q_full;
    logic        q_push;
    logic        q_pop;
    logic        q_valid;
    frame_desc_t push_desc;
    frame_desc_t pop_desc;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == CFG_DOT_SPACING) ? {24'd0, dot_spacing_reg}
                                                  : {24'd0, tri_spacing_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tri_spacing_reg <= TRI_SPACING_RST;
            dot_spacing_reg <= DOT_SPACING_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == CFG_TRI_SPACING) tri_spacing_reg <= pwdata[7:0];
            if (paddr[2] == CFG_DOT_SPACING) dot_spacing_reg <= pwdata[7:0];
        end
    end

    lcg_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_temperature_c (s_temperature_c),
        .tri_spacing     (tri_spacing_reg),
        .dot_spacing     (dot_spacing_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_desc          (push_desc)
    );

    lcg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_desc  (pop_desc)
    );

    lcg_back #(
        .NUM_PIXELS (NUM_PIXELS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_desc        (pop_desc),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_index (m_pixel_index),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_last        (m_last)
    );

endmodule

[rtl/core/lcg_front.sv]
// Front end: accepts button and tick items, keeps the effect state, issues frame descriptors.
// Depends on lcg_pkg.
`timescale 1ns / 1ps

module lcg_front
    import lcg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_operation,
    input  logic signed [7:0] s_temperature_c,
    input  logic [7:0]        tri_spacing,
    input  logic [7:0]        dot_spacing,
    input  logic              q_full,
    output logic              q_push,
    output frame_desc_t       q_desc
);

    effect_t    effect_mode_reg, effect_mode_next;
    logic [3:0] fade_speed_reg, fade_speed_next;
    logic [7:0] single_pos_reg, single_pos_next;
    logic [7:0] tri_pos_reg, tri_pos_next;
    logic [7:0] dot_pos_reg, dot_pos_next;
    logic [7:0] fade_cnt_reg, fade_cnt_next;
    logic       paused_reg, paused_next;
    logic [6:0] tick_reg, tick_next;

    logic       accept;
    logic       want_render;
    logic       fire;
    logic       fading;
    logic [6:0] tick_inc;
    logic [7:0] ten_speed;
    logic [7:0] period;
    logic [7:0] fade_inc;
    logic [7:0] temp_pos;

    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign fading    = (effect_mode_reg == EFF_SINGLE_FADE) || (effect_mode_reg == EFF_TRI_FADE);
    assign tick_inc  = tick_reg + 7'd1;
    assign ten_speed = {1'b0, fade_speed_reg, 3'b000} + {3'b000, fade_speed_reg, 1'b0};
    assign period    = PERIOD_BASE - ten_speed;
    assign fade_inc  = fade_cnt_reg + 8'd1;

    always_comb begin
        if (s_temperature_c <= 8'sd0) begin
            temp_pos = TEMP_COLD_POS;
        end else if (s_temperature_c >= TEMP_HOT_C) begin
            temp_pos = TEMP_HOT_POS;
        end else begin
            temp_pos = TEMP_COLD_POS - {s_temperature_c[5:0], 2'b00};
        end
    end

    always_comb begin
        effect_mode_next = effect_mode_reg;
        fade_speed_next  = fade_speed_reg;
        single_pos_next  = single_pos_reg;
        tri_pos_next     = tri_pos_reg;
        dot_pos_next     = dot_pos_reg;
        paused_next      = paused_reg;
        tick_next        = tick_reg;
        want_render      = 1'b0;
        unique case (s_operation)
            OP_TICK: begin
                if ({1'b0, tick_inc} >= period) begin
                    tick_next   = 7'd0;
                    want_render = 1'b1;
                end else begin
                    tick_next = tick_inc;
                end
            end
            OP_NEXT: begin
                effect_mode_next = (effect_mode_reg == EFF_TEMP) ? EFF_SINGLE
                                   : effect_t'(effect_mode_reg + 3'd1);
                want_render = 1'b1;
            end
            OP_PREV: begin
                effect_mode_next = (effect_mode_reg == EFF_SINGLE) ? EFF_TEMP
                                   : effect_t'(effect_mode_reg - 3'd1);
                want_render = 1'b1;
            end
            OP_UP: begin
                if (fading) begin
                    if (fade_speed_reg < SPEED_MAX) fade_speed_next = fade_speed_reg + 4'd1;
                end else if (effect_mode_reg == EFF_SINGLE) begin
                    single_pos_next = single_pos_reg + 8'd1;
                    want_render     = 1'b1;
                end else if (effect_mode_reg == EFF_TRI) begin
                    tri_pos_next = tri_pos_reg + 8'd1;
                    want_render  = 1'b1;
                end else if (effect_mode_reg == EFF_DOT) begin
                    dot_pos_next = dot_pos_reg + 8'd1;
                    want_render  = 1'b1;
                end
            end
            OP_DOWN: begin
                if (fading) begin
                    if (fade_speed_reg > SPEED_MIN) fade_speed_next = fade_speed_reg - 4'd1;
                end else if (effect_mode_reg == EFF_SINGLE) begin
                    single_pos_next = single_pos_reg - 8'd1;
                    want_render     = 1'b1;
                end else if (effect_mode_reg == EFF_TRI) begin
                    tri_pos_next = tri_pos_reg - 8'd1;
                    want_render  = 1'b1;
                end
            end
            OP_PAUSE: begin
                paused_next = 1'b1;
            end
            OP_UNPAUSE: begin
                if (paused_reg) begin
                    paused_next = 1'b0;
                    want_render = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign fire = want_render && !paused_next;

    always_comb begin
        fade_cnt_next = fade_cnt_reg;
        q_desc.kind   = KIND_SAME;
        q_desc.base   = single_pos_next;
        q_desc.step   = 8'd0;
        unique case (effect_mode_next)
            EFF_SINGLE: begin
            end
            EFF_SINGLE_FADE: begin
                if (fire) fade_cnt_next = fade_inc;
                q_desc.base = fade_inc;
            end
            EFF_TRI: begin
                q_desc.kind = KIND_TRI;
                q_desc.base = tri_pos_next;
                q_desc.step = tri_spacing;
            end
            EFF_TRI_FADE: begin
                if (fire) fade_cnt_next = fade_inc;
                q_desc.kind = KIND_TRI;
                q_desc.base = fade_inc;
                q_desc.step = TRI_FADE_STEP;
            end
            EFF_DOT: begin
                q_desc.kind = KIND_DOT;
                q_desc.base = dot_pos_next;
                q_desc.step = dot_spacing;
            end
            EFF_DOT_FADE: begin
                if (fire) fade_cnt_next = fade_inc;
                q_desc.kind = KIND_DOT;
                q_desc.base = fade_inc;
                q_desc.step = dot_spacing;
            end
            EFF_TEMP: begin
                q_desc.base = temp_pos;
            end
            default: begin
            end
        endcase
    end

    assign q_push = accept && fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            effect_mode_reg <= EFF_SINGLE;
            fade_speed_reg  <= FADE_SPEED_RST;
            single_pos_reg  <= 8'd0;
            tri_pos_reg     <= 8'd0;
            dot_pos_reg     <= 8'd0;
            fade_cnt_reg    <= 8'd0;
            paused_reg      <= 1'b0;
            tick_reg        <= 7'd0;
        end else if (accept) begin
            effect_mode_reg <= effect_mode_next;
            fade_speed_reg  <= fade_speed_next;
            single_pos_reg  <= single_pos_next;
            tri_pos_reg     <= tri_pos_next;
            dot_pos_reg     <= dot_pos_next;
            fade_cnt_reg    <= fade_cnt_next;
            paused_reg      <= paused_next;
            tick_reg        <= tick_next;
        end
    end

endmodule

[rtl/core/lcg_queue.sv]
// Two-entry queue of frame descriptors between the front end and the pixel engine.
// Depends on lcg_pkg.
`timescale 1ns / 1ps

module lcg_queue
    import lcg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  frame_desc_t push_desc,
    output logic        full,
    input  logic        pop,
    output logic        valid,
    output frame_desc_t pop_desc
);

    frame_desc_t entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign pop_desc = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

[rtl/core/lcg_back.sv]
// Pixel engine: walks one frame descriptor over all pixels and drives the result channel.
// Depends on lcg_pkg.
`timescale 1ns / 1ps

module lcg_back
    import lcg_pkg::*;
#(
    parameter int NUM_PIXELS = NUM_PIXELS_DEF
)
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    input  frame_desc_t            q_desc,
    output logic                   q_pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [PIXEL_IDX_W-1:0] m_pixel_index,
    output logic [7:0]             m_red,
    output logic [7:0]             m_green,
    output logic [7:0]             m_blue,
    output logic                   m_last
);

    localparam int CW = $clog2(NUM_PIXELS);
    localparam int FW = $clog2(NUM_PIXELS + 3);

    logic                   busy_reg, busy_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [FW-1:0]          frac_reg, frac_next;
    logic [7:0]             pos_reg, pos_next;
    logic [7:0]             step_reg, step_next;
    kind_t                  kind_reg, kind_next;
    logic                   m_valid_reg, m_valid_next;
    logic [PIXEL_IDX_W-1:0] m_pixel_index_reg, m_pixel_index_next;
    rgb_t                   m_rgb_reg, m_rgb_next;
    logic                   m_last_reg, m_last_next;

    logic          adv;
    logic          last_pix;
    logic [FW-1:0] frac_sum;
    logic [8:0]    dot_sum;

    assign adv      = !m_valid_reg || m_ready;
    assign last_pix = (cnt_reg == CW'(NUM_PIXELS - 1));
    assign frac_sum = frac_reg + FW'(3);
    assign dot_sum  = {1'b0, pos_reg} + {1'b0, step_reg};
    assign q_pop    = !busy_reg && q_valid;

    always_comb begin
        busy_next          = busy_reg;
        cnt_next           = cnt_reg;
        frac_next          = frac_reg;
        pos_next           = pos_reg;
        step_next          = step_reg;
        kind_next          = kind_reg;
        m_valid_next       = m_valid_reg;
        m_pixel_index_next = m_pixel_index_reg;
        m_rgb_next         = m_rgb_reg;
        m_last_next        = m_last_reg;
        if (q_pop) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            frac_next = '0;
            kind_next = q_desc.kind;
            step_next = q_desc.step;
            pos_next  = (q_desc.kind == KIND_DOT && q_desc.base == WHEEL_MAX) ? 8'd0
                        : q_desc.base;
        end
        if (adv) begin
            m_valid_next = busy_reg;
            if (busy_reg) begin
                m_pixel_index_next = PIXEL_IDX_W'(cnt_reg);
                m_rgb_next         = wheel(pos_reg);
                m_last_next        = last_pix;
                if (last_pix) begin
                    busy_next = 1'b0;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                    unique case (kind_reg)
                        KIND_TRI: begin
                            if (frac_sum >= FW'(NUM_PIXELS)) begin
                                frac_next = frac_sum - FW'(NUM_PIXELS);
                                pos_next  = pos_reg + step_reg;
                            end else begin
                                frac_next = frac_sum;
                            end
                        end
                        KIND_DOT: begin
                            pos_next = (dot_sum >= {1'b0, WHEEL_MAX})
                                       ? 8'(dot_sum - {1'b0, WHEEL_MAX}) : dot_sum[7:0];
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg           <= cnt_next;
        frac_reg          <= frac_next;
        pos_reg           <= pos_next;
        step_reg          <= step_next;
        kind_reg          <= kind_next;
        m_pixel_index_reg <= m_pixel_index_next;
        m_rgb_reg         <= m_rgb_next;
        m_last_reg        <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_index = m_pixel_index_reg;
    assign m_red         = m_rgb_reg.r;
    assign m_green       = m_rgb_reg.g;
    assign m_blue        = m_rgb_reg.b;
    assign m_last        = m_last_reg;

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> (m_pixel_index_reg == PIXEL_IDX_W'(NUM_PIXELS - 1)))
        else $error("last flag on a pixel other than the final one");

    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && adv && !last_pix) |=> (busy_reg && cnt_reg == $past(cnt_reg) + CW'(1)))
        else $error("pixel counter skipped or stalled while emitting");

    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !(adv && last_pix)) |=> busy_reg)
        else $error("frame dropped before its final pixel");

endmodule
